@@ src/dcwt_pkg.sv @@
package dcwt_pkg;

   // fixed field widths
   localparam int unsigned ACTW  = 3;
   localparam int unsigned CIDW  = 6;
   localparam int unsigned CNTW  = 16;
   localparam int unsigned TGTW  = 15;
   localparam int unsigned FIBW  = 7;
   localparam int unsigned THRW  = 4;
   localparam int unsigned STW   = 3;
   localparam int unsigned ENTW  = TGTW + FIBW + 1 + THRW;

   // action codes
   localparam logic [ACTW-1:0] ACT_ACQUIRE     = 3'd0;
   localparam logic [ACTW-1:0] ACT_RELEASE     = 3'd1;
   localparam logic [ACTW-1:0] ACT_RELEASE_TGT = 3'd2;
   localparam logic [ACTW-1:0] ACT_ADD         = 3'd3;
   localparam logic [ACTW-1:0] ACT_WAIT        = 3'd4;

   // status codes
   localparam logic [STW-1:0] ST_OK         = 3'd0;
   localparam logic [STW-1:0] ST_NO_COUNTER = 3'd1;
   localparam logic [STW-1:0] ST_SLOTS_FULL = 3'd2;
   localparam logic [STW-1:0] ST_OFF_TARGET = 3'd3;
   localparam logic [STW-1:0] ST_ZERO_AMT   = 3'd4;
   localparam logic [STW-1:0] ST_MUST_WAIT  = 3'd5;

   // result kinds
   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_WAKE = 1'b1;

   typedef struct packed {
      logic clr_en;
      logic load;
      logic exec;
      logic scan_en;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic go_scan;
      logic scan_end;
   } sts_type;

endpackage

@@ src/dcwt_ctrl.sv @@
module dcwt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dcwt_pkg::sts_type sts,
   output dcwt_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_EXEC  = 4'b0100,
      S_SCAN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.load = start;
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.go_scan ? S_SCAN : S_IDLE;
         end
         S_SCAN: begin
            cmd.scan_en = 1'b1;
            if (sts.scan_end) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ src/dcwt_datapath.sv @@
module dcwt_datapath #(
   parameter int unsigned NUM_COUNTERS = 64,
   parameter int unsigned WAIT_SLOTS   = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dcwt_pkg::cmd_type                 cmd,
   output dcwt_pkg::sts_type                 sts,
   input  logic [dcwt_pkg::ACTW-1:0]         req_action,
   input  logic [dcwt_pkg::CIDW-1:0]         req_counter_id,
   input  logic signed [dcwt_pkg::CNTW-1:0]  req_amount,
   input  logic [dcwt_pkg::TGTW-1:0]         req_target,
   input  logic [dcwt_pkg::FIBW-1:0]         req_fiber_id,
   input  logic                              req_pinned,
   input  logic [dcwt_pkg::THRW-1:0]         req_thread_id,
   output logic                              rsp_strobe,
   output logic                              rsp_kind,
   output logic [dcwt_pkg::STW-1:0]          rsp_status,
   output logic [dcwt_pkg::CIDW-1:0]         rsp_counter_id_res,
   output logic signed [dcwt_pkg::CNTW-1:0]  rsp_count_value,
   output logic [dcwt_pkg::FIBW-1:0]         rsp_wake_fiber,
   output logic                              rsp_wake_pinned,
   output logic [dcwt_pkg::THRW-1:0]         rsp_wake_thread,
   output logic                              rsp_last
);

   localparam int unsigned CIW    = $clog2(NUM_COUNTERS);
   localparam int unsigned FLW    = $clog2(NUM_COUNTERS + 1);
   localparam int unsigned SIW    = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
   localparam int unsigned SCW    = $clog2(WAIT_SLOTS + 1);
   localparam int unsigned SAW    = $clog2(NUM_COUNTERS * WAIT_SLOTS);
   localparam int unsigned CNTW   = dcwt_pkg::CNTW;
   localparam int unsigned CWW    = 1 + CNTW + WAIT_SLOTS;
   localparam int unsigned ENTW   = dcwt_pkg::ENTW;
   localparam int unsigned CID_IN = 2 ** dcwt_pkg::CIDW;

   typedef logic [CIW-1:0] cid_tab_type [CID_IN];

   function automatic cid_tab_type build_cid_tab();
      cid_tab_type t;
      for (int i = 0; i < CID_IN; i++) t[i] = CIW'(i % NUM_COUNTERS);
      return t;
   endfunction

   localparam cid_tab_type CID_TAB = build_cid_tab();

   // memories
   logic [CWW-1:0]  ctr_mem  [NUM_COUNTERS];
   logic [CIW-1:0]  fifo_mem [NUM_COUNTERS];
   logic [ENTW-1:0] slot_mem [NUM_COUNTERS * WAIT_SLOTS];

   // latched item
   logic [dcwt_pkg::ACTW-1:0]  act_ff;
   logic [CIW-1:0]             cidx_ff;
   logic signed [CNTW-1:0]     amount_ff;
   logic [dcwt_pkg::TGTW-1:0]  target_ff;
   logic [dcwt_pkg::FIBW-1:0]  fib_ff;
   logic                       pin_ff;
   logic [dcwt_pkg::THRW-1:0]  thr_ff;

   logic [CWW-1:0]  ctr_rd_ff;
   logic [CIW-1:0]  fifo_rd_ff;
   logic            fifo_ok_ff;
   logic [ENTW-1:0] srd_ff;

   logic [CIW-1:0] head_ff, head_in, tail_ff, tail_in, clr_idx_ff, clr_idx_in;
   logic [FLW-1:0] fill_ff, fill_in;
   logic           wrap_ff, wrap_in;

   logic [WAIT_SLOTS-1:0]  mask_ff, mask_in;
   logic signed [CNTW-1:0] nv_ff, nv_in;
   logic                   taken_ff, taken_in;
   logic [SCW-1:0]         sidx_ff, sidx_in;
   logic                   pend_ff, pend_in;
   logic [SIW-1:0]         pidx_ff, pidx_in;

   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic                              rsp_kind_ff, rsp_kind_in;
   logic [dcwt_pkg::STW-1:0]          rsp_status_ff, rsp_status_in;
   logic [dcwt_pkg::CIDW-1:0]         rsp_cid_ff, rsp_cid_in;
   logic signed [CNTW-1:0]            rsp_cnt_ff, rsp_cnt_in;
   logic [dcwt_pkg::FIBW-1:0]         rsp_fib_ff, rsp_fib_in;
   logic                              rsp_pin_ff, rsp_pin_in;
   logic [dcwt_pkg::THRW-1:0]         rsp_thr_ff, rsp_thr_in;
   logic                              rsp_last_ff, rsp_last_in;

   // write ports and memory addresses
   logic            ctr_we, fifo_we, slot_we;
   logic [CIW-1:0]  ctr_wa;
   logic [CWW-1:0]  ctr_wd;
   logic [SAW-1:0]  slot_addr;
   logic [CIW-1:0]  cid_rd;

   // decoded read word
   logic                   cur_taken;
   logic signed [CNTW-1:0] cur_cnt;
   logic [WAIT_SLOTS-1:0]  cur_mask;
   logic                   on_tgt;
   logic signed [CNTW:0]   sum;
   logic signed [CNTW-1:0] sat;
   logic [CIW-1:0]         got;
   logic                   issue;
   logic                   give_ok;
   logic [dcwt_pkg::TGTW-1:0] s_tgt;
   logic [WAIT_SLOTS-1:0]  mask_clr;

   assign cid_rd    = CID_TAB[req_counter_id];
   assign cur_taken = ctr_rd_ff[CWW-1];
   assign cur_cnt   = ctr_rd_ff[CWW-2 -: CNTW];
   assign cur_mask  = ctr_rd_ff[WAIT_SLOTS-1:0];
   assign on_tgt    = !cur_cnt[CNTW-1] && (cur_cnt[CNTW-2:0] == target_ff);
   assign sum       = {cur_cnt[CNTW-1], cur_cnt} + {amount_ff[CNTW-1], amount_ff};
   assign sat       = (sum[CNTW] != sum[CNTW-1]) ?
                      (sum[CNTW] ? {1'b1, {(CNTW-1){1'b0}}} : {1'b0, {(CNTW-1){1'b1}}})
                      : sum[CNTW-1:0];
   assign got       = fifo_ok_ff ? fifo_rd_ff : head_ff;
   assign give_ok   = cur_taken && (fill_ff < FLW'(NUM_COUNTERS));
   assign issue     = (sidx_ff < SCW'(WAIT_SLOTS));
   assign slot_addr = SAW'(cidx_ff) * SAW'(WAIT_SLOTS) + SAW'(sidx_ff);
   assign s_tgt     = srd_ff[ENTW-1 -: dcwt_pkg::TGTW];

   always_comb begin
      mask_clr = mask_ff;
      mask_clr[sidx_ff[SIW-1:0]] = 1'b0;
   end

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      fill_in    = fill_ff;
      wrap_in    = wrap_ff;
      clr_idx_in = clr_idx_ff;
      mask_in    = mask_ff;
      nv_in      = nv_ff;
      taken_in   = taken_ff;
      sidx_in    = sidx_ff;
      pend_in    = 1'b0;
      pidx_in    = pidx_ff;
      ctr_we     = 1'b0;
      ctr_wa     = cidx_ff;
      ctr_wd     = {taken_ff, nv_ff, mask_ff};
      fifo_we    = 1'b0;
      slot_we    = 1'b0;
      sts        = '0;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = dcwt_pkg::KIND_DONE;
      rsp_status_in = dcwt_pkg::ST_OK;
      rsp_cid_in    = dcwt_pkg::CIDW'(cidx_ff);
      rsp_cnt_in    = cur_cnt;
      rsp_fib_in    = '0;
      rsp_pin_in    = 1'b0;
      rsp_thr_in    = '0;
      rsp_last_in   = 1'b1;

      if (cmd.clr_en) begin
         ctr_we       = 1'b1;
         ctr_wa       = clr_idx_ff;
         ctr_wd       = {1'b0, {CNTW{1'b0}}, {WAIT_SLOTS{1'b1}}};
         clr_idx_in   = clr_idx_ff + CIW'(1);
         sts.clr_last = (clr_idx_ff == CIW'(NUM_COUNTERS - 1));
      end

      if (cmd.exec) begin
         unique case (act_ff)
            dcwt_pkg::ACT_ACQUIRE: begin
               rsp_strobe_in = 1'b1;
               rsp_cnt_in    = '0;
               if (fill_ff == '0) begin
                  rsp_status_in = dcwt_pkg::ST_NO_COUNTER;
                  rsp_cid_in    = '0;
               end else begin
                  ctr_we     = 1'b1;
                  ctr_wa     = got;
                  ctr_wd     = {1'b1, {CNTW{1'b0}}, {WAIT_SLOTS{1'b1}}};
                  head_in    = (head_ff == CIW'(NUM_COUNTERS - 1)) ? '0 : head_ff + CIW'(1);
                  fill_in    = fill_ff - FLW'(1);
                  rsp_cid_in = dcwt_pkg::CIDW'(got);
               end
            end
            dcwt_pkg::ACT_RELEASE, dcwt_pkg::ACT_RELEASE_TGT: begin
               rsp_strobe_in = 1'b1;
               if (act_ff == dcwt_pkg::ACT_RELEASE_TGT && !on_tgt) begin
                  rsp_status_in = dcwt_pkg::ST_OFF_TARGET;
               end else if (give_ok) begin
                  ctr_we  = 1'b1;
                  ctr_wd  = {1'b0, cur_cnt, cur_mask};
                  fifo_we = 1'b1;
                  tail_in = (tail_ff == CIW'(NUM_COUNTERS - 1)) ? '0 : tail_ff + CIW'(1);
                  if (tail_ff == CIW'(NUM_COUNTERS - 1)) wrap_in = 1'b1;
                  fill_in = fill_ff + FLW'(1);
               end
            end
            dcwt_pkg::ACT_ADD: begin
               if (amount_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = dcwt_pkg::ST_ZERO_AMT;
               end else begin
                  ctr_we      = 1'b1;
                  ctr_wd      = {cur_taken, sat, cur_mask};
                  nv_in       = sat;
                  mask_in     = cur_mask;
                  taken_in    = cur_taken;
                  sidx_in     = '0;
                  sts.go_scan = 1'b1;
               end
            end
            dcwt_pkg::ACT_WAIT: begin
               if (cur_mask == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = dcwt_pkg::ST_SLOTS_FULL;
               end else if (on_tgt) begin
                  rsp_strobe_in = 1'b1;
               end else begin
                  nv_in       = cur_cnt;
                  mask_in     = cur_mask;
                  taken_in    = cur_taken;
                  sidx_in     = '0;
                  sts.go_scan = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.scan_en) begin
         rsp_cnt_in = nv_ff;
         if (act_ff == dcwt_pkg::ACT_ADD) begin
            // one slot read issued per cycle, checked the cycle after
            pend_in = issue;
            pidx_in = sidx_ff[SIW-1:0];
            if (issue) sidx_in = sidx_ff + SCW'(1);
            if (pend_ff && !mask_ff[pidx_ff] && !nv_ff[CNTW-1]
                && (s_tgt == nv_ff[CNTW-2:0])) begin
               mask_in[pidx_ff] = 1'b1;
               rsp_strobe_in    = 1'b1;
               rsp_kind_in      = dcwt_pkg::KIND_WAKE;
               rsp_fib_in       = srd_ff[ENTW-dcwt_pkg::TGTW-1 -: dcwt_pkg::FIBW];
               rsp_pin_in       = srd_ff[dcwt_pkg::THRW];
               rsp_thr_in       = srd_ff[dcwt_pkg::THRW] ? srd_ff[dcwt_pkg::THRW-1:0] : '0;
               rsp_last_in      = 1'b0;
            end
            if (!issue && !pend_ff) begin
               ctr_we        = 1'b1;
               rsp_strobe_in = 1'b1;
               sts.scan_end  = 1'b1;
            end
         end else begin
            // first free slot search for a wait
            if (mask_ff[sidx_ff[SIW-1:0]]) begin
               slot_we       = 1'b1;
               mask_in       = mask_clr;
               ctr_we        = 1'b1;
               ctr_wd        = {taken_ff, nv_ff, mask_clr};
               rsp_strobe_in = 1'b1;
               rsp_status_in = dcwt_pkg::ST_MUST_WAIT;
               sts.scan_end  = 1'b1;
            end else begin
               sidx_in = sidx_ff + SCW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctr_we) ctr_mem[ctr_wa] <= ctr_wd;
      ctr_rd_ff <= ctr_mem[cid_rd];
      if (fifo_we) fifo_mem[tail_ff] <= cidx_ff;
      fifo_rd_ff <= fifo_mem[head_ff];
      if (slot_we) slot_mem[slot_addr] <= {target_ff, fib_ff, pin_ff, thr_ff};
      srd_ff <= slot_mem[slot_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff    <= req_action;
         cidx_ff   <= cid_rd;
         amount_ff <= req_amount;
         target_ff <= req_target;
         fib_ff    <= req_fiber_id;
         pin_ff    <= req_pinned;
         thr_ff    <= req_thread_id;
      end
      fifo_ok_ff    <= wrap_ff || (head_ff < tail_ff);
      mask_ff       <= mask_in;
      nv_ff         <= nv_in;
      taken_ff      <= taken_in;
      sidx_ff       <= sidx_in;
      pidx_ff       <= pidx_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cid_ff    <= rsp_cid_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_fib_ff    <= rsp_fib_in;
      rsp_pin_ff    <= rsp_pin_in;
      rsp_thr_ff    <= rsp_thr_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= FLW'(NUM_COUNTERS);
         wrap_ff       <= 1'b0;
         clr_idx_ff    <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         wrap_ff       <= wrap_in;
         clr_idx_ff    <= clr_idx_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_counter_id_res = rsp_cid_ff;
   assign rsp_count_value    = rsp_cnt_ff;
   assign rsp_wake_fiber     = rsp_fib_ff;
   assign rsp_wake_pinned    = rsp_pin_ff;
   assign rsp_wake_thread    = rsp_thr_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

@@ src/dependency_counter_wait_table.sv @@
// Dependency counter pool with waiter slots. An item is taken when start is high and busy
// low; results come out one per cycle with rsp_strobe, and the receiver cannot stall them,
// so it must take every strobed result. Acquire, release and the early answers of add and
// wait pass through a counter word read, then execute. An add scans its counter's slots
// one per cycle through the slot memory read port, with up to WAIT_SLOTS wake items ahead
// of the final completion. A wait that has to park searches for the first free slot one
// per cycle. After reset a clearing pass runs over every word of the counter memory, with
// busy held high. rsp_last marks the final item of each action; unknown actions give none.
module dependency_counter_wait_table #(
   parameter int unsigned NUM_COUNTERS = 64,
   parameter int unsigned WAIT_SLOTS   = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // command side
   input  logic                              start,
   output logic                              busy,
   input  logic [dcwt_pkg::ACTW-1:0]         req_action,
   input  logic [dcwt_pkg::CIDW-1:0]         req_counter_id,
   input  logic signed [dcwt_pkg::CNTW-1:0]  req_amount,
   input  logic [dcwt_pkg::TGTW-1:0]         req_target,
   input  logic [dcwt_pkg::FIBW-1:0]         req_fiber_id,
   input  logic                              req_pinned,
   input  logic [dcwt_pkg::THRW-1:0]         req_thread_id,
   // result side
   output logic                              rsp_strobe,
   output logic                              rsp_kind,
   output logic [dcwt_pkg::STW-1:0]          rsp_status,
   output logic [dcwt_pkg::CIDW-1:0]         rsp_counter_id_res,
   output logic signed [dcwt_pkg::CNTW-1:0]  rsp_count_value,
   output logic [dcwt_pkg::FIBW-1:0]         rsp_wake_fiber,
   output logic                              rsp_wake_pinned,
   output logic [dcwt_pkg::THRW-1:0]         rsp_wake_thread,
   output logic                              rsp_last
);

   // command and status between sequencer and datapath
   dcwt_pkg::cmd_type cmd;
   dcwt_pkg::sts_type sts;

   // sequencer: clearing pass, idle, execute, slot scan
   dcwt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // counter memory, free list, slot memory and the result register
   dcwt_datapath #(
      .NUM_COUNTERS (NUM_COUNTERS),
      .WAIT_SLOTS   (WAIT_SLOTS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_action),
      .req_counter_id     (req_counter_id),
      .req_amount         (req_amount),
      .req_target         (req_target),
      .req_fiber_id       (req_fiber_id),
      .req_pinned         (req_pinned),
      .req_thread_id      (req_thread_id),
      .rsp_strobe         (rsp_strobe),
      .rsp_kind           (rsp_kind),
      .rsp_status         (rsp_status),
      .rsp_counter_id_res (rsp_counter_id_res),
      .rsp_count_value    (rsp_count_value),
      .rsp_wake_fiber     (rsp_wake_fiber),
      .rsp_wake_pinned    (rsp_wake_pinned),
      .rsp_wake_thread    (rsp_wake_thread),
      .rsp_last           (rsp_last)
   );

endmodule

@@ src/dcwt_checker.sv @@
module dcwt_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_strobe,
   input logic                     rsp_kind,
   input logic [dcwt_pkg::STW-1:0] rsp_status,
   input logic                     rsp_last
);

   // a wake is never the final item of an action
   a_wake_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind == dcwt_pkg::KIND_WAKE |-> !rsp_last)
      else $error("wake item marked last");

   // every completion closes its action
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind == dcwt_pkg::KIND_DONE |-> rsp_last)
      else $error("completion item not marked last");

   // an accepted item keeps the block busy the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("not busy after accepting an item");

   // the final item appears once the block is idle again
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> !busy)
      else $error("final item while still busy");

   // wakes carry status ok only
   a_wake_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind == dcwt_pkg::KIND_WAKE |-> rsp_status == dcwt_pkg::ST_OK)
      else $error("wake item with error status");

endmodule

bind dependency_counter_wait_table dcwt_checker u_dcwt_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_kind   (rsp_kind),
   .rsp_status (rsp_status),
   .rsp_last   (rsp_last)
);

@@ sim/tb_dependency_counter_wait_table.sv @@
`timescale 1ns / 1ps

import dcwt_pkg::*;

typedef struct {
   logic                  kind;
   logic [STW-1:0]        status;
   logic [CIDW-1:0]       cid;
   logic signed [CNTW-1:0] cnt;
   logic [FIBW-1:0]       fib;
   logic                  pin;
   logic [THRW-1:0]       thr;
   logic                  last;
} wait_table_result_type;

// mirror of the counter pool, its free list and the waiter slots
class wait_table_scoreboard;
   localparam int NCTR  = 64;
   localparam int NSLOT = 32;

   logic signed [CNTW-1:0] count_mem [NCTR];
   int unsigned            free_list [NCTR];
   int unsigned            head, tail, fill;
   bit                     owned [NCTR];
   bit                     slot_open [NCTR][NSLOT];
   logic [TGTW-1:0]        slot_tgt [NCTR][NSLOT];
   logic [FIBW-1:0]        slot_fib [NCTR][NSLOT];
   logic                   slot_pin [NCTR][NSLOT];
   logic [THRW-1:0]        slot_thr [NCTR][NSLOT];
   wait_table_result_type  pending_q [$];
   int                     errors, items, wakes, checked;
   int                     status_seen [8];

   function new();
      for (int i = 0; i < NCTR; i++) begin
         count_mem[i] = '0;
         free_list[i] = i;
         owned[i]     = 0;
         for (int s = 0; s < NSLOT; s++) slot_open[i][s] = 1;
      end
      head = 0;
      tail = 0;
      fill = NCTR;
   endfunction

   function void push(logic kind, logic [STW-1:0] st, int c, int v, logic [FIBW-1:0] f,
                      logic p, logic [THRW-1:0] t, logic l);
      wait_table_result_type r;
      r.kind = kind; r.status = st; r.cid = c[CIDW-1:0]; r.cnt = v[CNTW-1:0];
      r.fib = f; r.pin = p; r.thr = t; r.last = l;
      pending_q.push_back(r);
      status_seen[st]++;
      if (kind == KIND_WAKE) wakes++;
   endfunction

   function void put_back(int c);
      if (!owned[c] || fill >= NCTR) return;
      owned[c]        = 0;
      free_list[tail] = c;
      tail            = (tail + 1) % NCTR;
      fill++;
   endfunction

   // returns the counter handed out by an acquire, else -1
   function int note(logic [ACTW-1:0] act, logic [CIDW-1:0] cid, logic signed [CNTW-1:0] amt,
                     logic [TGTW-1:0] tgt, logic [FIBW-1:0] fib, logic pin,
                     logic [THRW-1:0] thr);
      int c, cur, nv, got, fs;
      c   = cid % NCTR;
      cur = count_mem[c];
      got = -1;
      if (act <= ACT_WAIT) items++;
      case (act)
         ACT_ACQUIRE: begin
            if (fill == 0) push(KIND_DONE, ST_NO_COUNTER, 0, 0, 0, 0, 0, 1);
            else begin
               got  = free_list[head] % NCTR;
               head = (head + 1) % NCTR;
               fill--;
               owned[got]     = 1;
               count_mem[got] = '0;
               for (int s = 0; s < NSLOT; s++) slot_open[got][s] = 1;
               push(KIND_DONE, ST_OK, got, 0, 0, 0, 0, 1);
            end
         end
         ACT_RELEASE: begin
            put_back(c);
            push(KIND_DONE, ST_OK, c, cur, 0, 0, 0, 1);
         end
         ACT_RELEASE_TGT: begin
            if (cur != int'(tgt)) push(KIND_DONE, ST_OFF_TARGET, c, cur, 0, 0, 0, 1);
            else begin
               put_back(c);
               push(KIND_DONE, ST_OK, c, cur, 0, 0, 0, 1);
            end
         end
         ACT_ADD: begin
            if (amt == 0) push(KIND_DONE, ST_ZERO_AMT, c, cur, 0, 0, 0, 1);
            else begin
               nv = cur + int'(amt);
               if (nv > 32767) nv = 32767;
               if (nv < -32768) nv = -32768;
               count_mem[c] = nv[CNTW-1:0];
               for (int s = 0; s < NSLOT; s++)
                  if (!slot_open[c][s] && int'(slot_tgt[c][s]) == nv) begin
                     push(KIND_WAKE, ST_OK, c, nv, slot_fib[c][s], slot_pin[c][s],
                          slot_pin[c][s] ? slot_thr[c][s] : '0, 0);
                     slot_open[c][s] = 1;
                  end
               push(KIND_DONE, ST_OK, c, nv, 0, 0, 0, 1);
            end
         end
         ACT_WAIT: begin
            fs = -1;
            for (int s = NSLOT - 1; s >= 0; s--) if (slot_open[c][s]) fs = s;
            if (fs < 0) push(KIND_DONE, ST_SLOTS_FULL, c, cur, 0, 0, 0, 1);
            else if (cur == int'(tgt)) push(KIND_DONE, ST_OK, c, cur, 0, 0, 0, 1);
            else begin
               slot_open[c][fs] = 0;
               slot_tgt[c][fs]  = tgt;
               slot_fib[c][fs]  = fib;
               slot_pin[c][fs]  = pin;
               slot_thr[c][fs]  = thr;
               push(KIND_DONE, ST_MUST_WAIT, c, cur, 0, 0, 0, 1);
            end
         end
         default: ;
      endcase
      return got;
   endfunction

   function void check(wait_table_result_type a);
      wait_table_result_type e;
      checked++;
      if (pending_q.size() == 0) begin
         $error("result with nothing expected: kind %0d status %0d", a.kind, a.status);
         errors++;
         return;
      end
      e = pending_q.pop_front();
      if (a.kind !== e.kind) begin
         $error("kind: expected %0d actual %0d", e.kind, a.kind); errors++; end
      if (a.status !== e.status) begin
         $error("status: expected %0d actual %0d", e.status, a.status); errors++; end
      if (a.cid !== e.cid) begin
         $error("counter_id_res: expected %0d actual %0d", e.cid, a.cid); errors++; end
      if (a.cnt !== e.cnt) begin
         $error("count_value: expected %0d actual %0d", e.cnt, a.cnt); errors++; end
      if (a.fib !== e.fib) begin
         $error("wake_fiber: expected %0d actual %0d", e.fib, a.fib); errors++; end
      if (a.pin !== e.pin) begin
         $error("wake_pinned: expected %0d actual %0d", e.pin, a.pin); errors++; end
      if (a.thr !== e.thr) begin
         $error("wake_thread: expected %0d actual %0d", e.thr, a.thr); errors++; end
      if (a.last !== e.last) begin
         $error("last: expected %0d actual %0d", e.last, a.last); errors++; end
   endfunction
endclass

module tb_dependency_counter_wait_table;

   localparam int IDLE_LIMIT = 5000;   // cycles without any handshake before giving up
   localparam int RAND_ITEMS = 250;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [ACTW-1:0]        req_action = ACT_ACQUIRE;
   logic [CIDW-1:0]        req_counter_id = '0;
   logic signed [CNTW-1:0] req_amount = '0;
   logic [TGTW-1:0]        req_target = '0;
   logic [FIBW-1:0]        req_fiber_id = '0;
   logic                   req_pinned = 1'b0;
   logic [THRW-1:0]        req_thread_id = '0;
   logic                   rsp_strobe, rsp_kind, rsp_wake_pinned, rsp_last;
   logic [STW-1:0]         rsp_status;
   logic [CIDW-1:0]        rsp_counter_id_res;
   logic signed [CNTW-1:0] rsp_count_value;
   logic [FIBW-1:0]        rsp_wake_fiber;
   logic [THRW-1:0]        rsp_wake_thread;

   wait_table_scoreboard sb = new();
   int  live_ctrs [$];      // counters currently handed out, used to steer the stimulus
   bit  keep_busy;          // stretch with no gaps on the command side
   int  idle_cycles;

   always #5 clock = ~clock;

   dependency_counter_wait_table u_dut (
      .clock, .reset, .start, .busy,
      .req_action, .req_counter_id, .req_amount, .req_target,
      .req_fiber_id, .req_pinned, .req_thread_id,
      .rsp_strobe, .rsp_kind, .rsp_status, .rsp_counter_id_res, .rsp_count_value,
      .rsp_wake_fiber, .rsp_wake_pinned, .rsp_wake_thread, .rsp_last
   );

   // results cannot be held off, so every strobed cycle is checked straight away
   always @(posedge clock) begin
      wait_table_result_type r;
      if (!reset && rsp_strobe) begin
         r.kind = rsp_kind; r.status = rsp_status; r.cid = rsp_counter_id_res;
         r.cnt = rsp_count_value; r.fib = rsp_wake_fiber; r.pin = rsp_wake_pinned;
         r.thr = rsp_wake_thread; r.last = rsp_last;
         sb.check(r);
      end
   end

   // watchdog: counts cycles with no item taken and no result out
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // mostly short gaps, a few long ones, none at all during busy stretches
   function automatic int pick_gap();
      if (keep_busy) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
      return $urandom_range(3, 40);
   endfunction

   // called just after a rising edge; returns with the item taken
   task automatic issue(logic [ACTW-1:0] act, logic [CIDW-1:0] cid, logic signed [CNTW-1:0] amt,
                        logic [TGTW-1:0] tgt, logic [FIBW-1:0] fib, logic pin,
                        logic [THRW-1:0] thr);
      int gap, got;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_action     <= act;
      req_counter_id <= cid;
      req_amount     <= amt;
      req_target     <= tgt;
      req_fiber_id   <= fib;
      req_pinned     <= pin;
      req_thread_id  <= thr;
      do @(posedge clock); while (busy);
      got = sb.note(act, cid, amt, tgt, fib, pin, thr);
      if (got >= 0) live_ctrs.push_back(got);
      if (act == ACT_RELEASE || (act == ACT_RELEASE_TGT && !sb.owned[cid]))
         foreach (live_ctrs[i]) if (live_ctrs[i] == cid) begin
            live_ctrs.delete(i);
            break;
         end
   endtask

   task automatic issue_rand_waiter(logic [ACTW-1:0] act, logic [CIDW-1:0] cid,
                                    logic signed [CNTW-1:0] amt, logic [TGTW-1:0] tgt);
      issue(act, cid, amt, tgt, 7'($urandom), 1'($urandom), 4'($urandom));
   endtask

   function automatic logic [CIDW-1:0] pick_counter();
      if (live_ctrs.size() > 0 && $urandom_range(0, 9) < 9)
         return CIDW'(live_ctrs[$urandom_range(0, live_ctrs.size() - 1)]);
      return CIDW'($urandom);
   endfunction

   initial begin
      int                     n, r, cur;
      logic [CIDW-1:0]        c;
      logic signed [CNTW-1:0] amt;
      logic [TGTW-1:0]        tgt;

      keep_busy = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unknown codes, release of an untouched counter, wake ordering,
      // zero amount, saturation both ways, conditional release, wait on target
      issue(3'd5, 6'd0, 16'sd0, 15'd0, 7'd0, 1'b0, 4'd0);
      issue(3'd7, 6'd63, -16'sd1, 15'h7fff, 7'h7f, 1'b1, 4'hf);
      issue(ACT_RELEASE, 6'd63, 16'sd0, 15'd0, 7'd0, 1'b0, 4'd0);
      issue(ACT_ACQUIRE, 6'd0, 16'sd0, 15'd0, 7'd0, 1'b0, 4'd0);
      issue(ACT_ACQUIRE, 6'd0, 16'sd0, 15'd0, 7'd0, 1'b0, 4'd0);
      issue(ACT_WAIT, 6'd0, 16'sd0, 15'd0, 7'd5, 1'b1, 4'd3);
      issue(ACT_WAIT, 6'd0, 16'sd0, 15'd2, 7'h7f, 1'b1, 4'hf);
      issue(ACT_WAIT, 6'd0, 16'sd0, 15'd2, 7'd0, 1'b0, 4'hf);
      issue(ACT_WAIT, 6'd0, 16'sd0, 15'h7fff, 7'd42, 1'b1, 4'd0);
      issue(ACT_ADD, 6'd0, 16'sd0, 15'd0, 7'd0, 1'b0, 4'd0);
      issue(ACT_ADD, 6'd0, 16'sd2, 15'd0, 7'd0, 1'b0, 4'd0);
      issue(ACT_ADD, 6'd0, 16'sh7fff, 15'd0, 7'd0, 1'b0, 4'd0);
      issue(ACT_ADD, 6'd0, -16'sd32768, 15'd0, 7'd0, 1'b0, 4'd0);
      issue(ACT_ADD, 6'd0, -16'sd32768, 15'd0, 7'd0, 1'b0, 4'd0);
      issue(ACT_WAIT, 6'd0, 16'sd0, 15'd0, 7'd9, 1'b0, 4'd1);
      issue(ACT_RELEASE_TGT, 6'd0, 16'sd0, 15'd5, 7'd0, 1'b0, 4'd0);
      issue(ACT_RELEASE_TGT, 6'd1, 16'sd0, 15'd0, 7'd0, 1'b0, 4'd0);
      issue(ACT_RELEASE, 6'd1, 16'sd0, 15'd0, 7'd0, 1'b0, 4'd0);
      issue(ACT_ADD, 6'd63, 16'sd1, 15'd0, 7'd0, 1'b0, 4'd0);
      issue(ACT_WAIT, 6'd63, 16'sd0, 15'd1, 7'd0, 1'b0, 4'd0);
      issue(ACT_RELEASE, 6'd0, 16'sd0, 15'd0, 7'd0, 1'b0, 4'd0);

      // random part: waits and small adds on handed-out counters so that wakes
      // happen often, with bursts that fill a counter's slots or drain the free list
      n = 0;
      while (n < RAND_ITEMS) begin
         if (n % 30 == 0) keep_busy = ($urandom_range(0, 3) == 0);
         r   = $urandom_range(0, 99);
         c   = pick_counter();
         cur = sb.count_mem[c];
         if (r < 2 && n + 33 <= RAND_ITEMS) begin
            // fill every slot of one counter, then one more
            for (int k = 0; k < 33; k++)
               issue_rand_waiter(ACT_WAIT, c, 16'sd0, 15'h7ffe);
            n += 33;
         end else if (r < 3 && n > 60 && n + 130 <= RAND_ITEMS) begin
            // drain the free list, then hand everything back
            for (int k = 0; k < 66; k++)
               issue(ACT_ACQUIRE, 6'd0, 16'sd0, 15'd0, 7'd0, 1'b0, 4'd0);
            for (int k = 0; k < 64; k++)
               issue(ACT_RELEASE, CIDW'(k), 16'sd0, 15'd0, 7'd0, 1'b0, 4'd0);
            n += 130;
         end else if (r < 6) begin
            issue(ACTW'($urandom_range(5, 7)), CIDW'($urandom), CNTW'($urandom),
                  TGTW'($urandom), 7'($urandom), 1'($urandom), 4'($urandom));
            n++;
         end else if (r < 16 || live_ctrs.size() == 0) begin
            issue(ACT_ACQUIRE, CIDW'($urandom), 16'sd0, 15'd0, 7'd0, 1'b0, 4'd0);
            n++;
         end else if (r < 21) begin
            issue(ACT_RELEASE, c, 16'sd0, 15'd0, 7'd0, 1'b0, 4'd0);
            n++;
         end else if (r < 27) begin
            tgt = ($urandom_range(0, 1) && cur >= 0) ? TGTW'(cur) : TGTW'($urandom);
            issue(ACT_RELEASE_TGT, c, 16'sd0, tgt, 7'd0, 1'b0, 4'd0);
            n++;
         end else if (r < 57) begin
            case ($urandom_range(0, 9))
               0:       amt = '0;
               1:       amt = CNTW'($urandom);
               2:       amt = -CNTW'($urandom_range(1, 3));
               default: amt = CNTW'($urandom_range(1, 3));
            endcase
            issue(ACT_ADD, c, amt, TGTW'($urandom), 7'($urandom), 1'($urandom), 4'($urandom));
            n++;
         end else begin
            if ($urandom_range(0, 9) == 0) tgt = TGTW'($urandom);
            else tgt = TGTW'((cur < 0 ? 0 : cur) + $urandom_range(0, 5));
            issue_rand_waiter(ACT_WAIT, c, CNTW'($urandom), tgt);
            n++;
         end
      end
      start <= 1'b0;

      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("%0d items, %0d results checked, %0d wakes", sb.items, sb.checked, sb.wakes);
      $display("status counts ok/none/full/off/zero/wait: %0d %0d %0d %0d %0d %0d",
               sb.status_seen[ST_OK], sb.status_seen[ST_NO_COUNTER],
               sb.status_seen[ST_SLOTS_FULL], sb.status_seen[ST_OFF_TARGET],
               sb.status_seen[ST_ZERO_AMT], sb.status_seen[ST_MUST_WAIT]);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ sim.f @@
src/dcwt_pkg.sv
src/dcwt_ctrl.sv
src/dcwt_datapath.sv
src/dependency_counter_wait_table.sv
src/dcwt_checker.sv
sim/tb_dependency_counter_wait_table.sv
